### src/mitchell_filter_weight_unit_macros.svh
// Assertion helpers for the Mitchell filter weight unit.
// Each helper samples on clk_i and is disabled while rst_ni is low.
`ifndef MITCHELL_FILTER_WEIGHT_UNIT_MACROS_SVH
`define MITCHELL_FILTER_WEIGHT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MFW_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mitchell filter weight unit: same-cycle check failed");
`define MFW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mitchell filter weight unit: next-cycle check failed");
`else
`define MFW_ASSERT_IMPLY(name, ante, cons)
`define MFW_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### src/mfw_pkg.sv
package mfw_pkg;

  // Register and result widths
  localparam int unsigned REG_W    = 16;
  localparam int unsigned WEIGHT_W = 16;

  // Register reset values
  localparam logic [REG_W-1:0] B_RESET     = 16'd10923;
  localparam logic [REG_W-1:0] C_RESET     = 16'd10923;
  localparam logic [REG_W-1:0] INV_X_RESET = 16'd8192;
  localparam logic [REG_W-1:0] INV_Y_RESET = 16'd8192;

  // Polynomial datapath widths (t in Q.16, t < 2 inside the filter)
  localparam int unsigned COEF_W = 24;
  localparam int unsigned T_W    = 17;
  localparam int unsigned T2_W   = 18;
  localparam int unsigned T3_W   = 19;
  localparam int unsigned PROD_W = 44;
  localparam int unsigned SUM_W  = 44;
  localparam int unsigned FRAC_SHIFT = 16;   // Q.16 fraction of t and its powers
  localparam int unsigned ONE15  = 32768;    // 1.0 in Q.15

  // Argument bit positions in the exact Q.26 value of t
  localparam int unsigned T26_ONE_BIT = 26;
  localparam int unsigned T26_TWO_BIT = 27;
  localparam int unsigned T26_DROP    = 10;

  // Kernel division by 6*2^15: round, shift by 2^16, then divide by 3
  localparam int unsigned M_W         = 28;
  localparam int unsigned Q_W         = 25;
  localparam int unsigned KER_W       = Q_W + 1;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [M_W-1:0] RECIP3 =
    M_W'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd3);
  localparam logic [SUM_W-1:0] KER_HALF = SUM_W'(98304);

  // Weight product Q.32 down to Q.14
  localparam int unsigned WPROD_W = 2 * KER_W;
  localparam int unsigned W_SHIFT = 18;
  localparam int unsigned WQ_W    = WPROD_W - W_SHIFT;
  localparam logic [WPROD_W-1:0] W_HALF = WPROD_W'(64'd1 << (W_SHIFT - 1));
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W - 1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W - 1){1'b0}}};

  // Pipeline depth: kernel stages plus product and output stages
  localparam int unsigned KER_STAGES = 7;
  localparam int unsigned PIPE_DEPTH = KER_STAGES + 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_B_VALUE     = 2'd0,
    CFG_C_VALUE     = 2'd1,
    CFG_INV_X_WIDTH = 2'd2,
    CFG_INV_Y_WIDTH = 2'd3
  } mfw_cfg_reg_e;

  // Seven cubic coefficients, times six, Q.15
  typedef struct packed {
    logic signed [COEF_W-1:0] p1_a3;
    logic signed [COEF_W-1:0] p1_a2;
    logic signed [COEF_W-1:0] p1_a0;
    logic signed [COEF_W-1:0] p2_a3;
    logic signed [COEF_W-1:0] p2_a2;
    logic signed [COEF_W-1:0] p2_a1;
    logic signed [COEF_W-1:0] p2_a0;
  } mfw_coef_t;

endpackage

### src/mitchell_filter_weight_unit.sv
// Mitchell-Netravali filter weight unit. Each input word carries a sample offset
// (offset_x, offset_y) in signed Q(COORD_WIDTH-12).12 and yields one output word,
// the separable weight K(x*inv_x_width)*K(y*inv_y_width) in signed Q2.14, rounded
// and saturated; offsets at or beyond the filter width give zero. The unit takes
// one word per clock while the output is not stalled, via a nine-stage pipeline
// (abs and width multiply, square, cube, coefficient products, sum, round,
// divide by three, kernel product, round and saturate). A stalled output holds
// the whole pipeline. B, C and both inverse widths must be written through the
// register port while no word is in flight; the unit does not enforce this.
`include "mitchell_filter_weight_unit_macros.svh"

module mitchell_filter_weight_unit #(
  parameter  int unsigned COORD_WIDTH = 16,
  localparam int unsigned IN_DATA_W   = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Register write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_addr_i,
  input  logic [mfw_pkg::REG_W-1:0]         cfg_wdata_i,
  // Offset stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,   // offset_x, offset_y
  // Weight stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mfw_pkg::WEIGHT_W-1:0]      m_axis_tdata    // weight
);

  // Configuration registers
  logic [mfw_pkg::REG_W-1:0] b_q, c_q, inv_x_q, inv_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q     <= mfw_pkg::B_RESET;
      c_q     <= mfw_pkg::C_RESET;
      inv_x_q <= mfw_pkg::INV_X_RESET;
      inv_y_q <= mfw_pkg::INV_Y_RESET;
    end else if (cfg_we_i) begin
      unique case (mfw_pkg::mfw_cfg_reg_e'(cfg_addr_i))
        mfw_pkg::CFG_B_VALUE:     b_q     <= cfg_wdata_i;
        mfw_pkg::CFG_C_VALUE:     c_q     <= cfg_wdata_i;
        mfw_pkg::CFG_INV_X_WIDTH: inv_x_q <= cfg_wdata_i;
        mfw_pkg::CFG_INV_Y_WIDTH: inv_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: advance unless a finished word waits at the output
  logic                             pipe_en;
  logic [mfw_pkg::PIPE_DEPTH-1:0]   valid_q;

  assign pipe_en       = ~valid_q[mfw_pkg::PIPE_DEPTH-1] | m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = valid_q[mfw_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[mfw_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Coefficients shared by both axes
  mfw_pkg::mfw_coef_t coef;

  mfw_coef u_coef (
    .clk_i  (clk_i),
    .b_i    (b_q),
    .c_i    (c_q),
    .coef_o (coef)
  );

  // One kernel pipeline per axis
  logic signed [mfw_pkg::KER_W-1:0] kx, ky;

  mfw_kernel #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_kernel_x (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .off_i    ($signed(s_axis_tdata[COORD_WIDTH-1:0])),
    .inv_i    (inv_x_q),
    .coef_i   (coef),
    .kernel_o (kx)
  );

  mfw_kernel #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_kernel_y (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .off_i    ($signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .inv_i    (inv_y_q),
    .coef_i   (coef),
    .kernel_o (ky)
  );

  // Product, rounding and saturation
  mfw_combine u_combine (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .kx_i     (kx),
    .ky_i     (ky),
    .weight_o (m_axis_tdata)
  );

  // Checks on pipeline control
  `MFW_ASSERT_IMPLY(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `MFW_ASSERT_NEXT(a_stall_holds_pipe, m_axis_tvalid && !m_axis_tready, $stable(valid_q))
  `MFW_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, valid_q[0])

endmodule

### src/mfw_coef.sv
module mfw_coef (
  input  logic                           clk_i,
  input  logic [mfw_pkg::REG_W-1:0]      b_i,
  input  logic [mfw_pkg::REG_W-1:0]      c_i,
  output mfw_pkg::mfw_coef_t             coef_o
);

  mfw_pkg::mfw_coef_t coef_d, coef_q;

  // Derive both cubic pieces from B and C
  always_comb begin
    coef_d.p1_a3 = mfw_pkg::COEF_W'(12 * mfw_pkg::ONE15 - 9 * int'(b_i) - 6 * int'(c_i));
    coef_d.p1_a2 = mfw_pkg::COEF_W'(-18 * mfw_pkg::ONE15 + 12 * int'(b_i) + 6 * int'(c_i));
    coef_d.p1_a0 = mfw_pkg::COEF_W'(6 * mfw_pkg::ONE15 - 2 * int'(b_i));
    coef_d.p2_a3 = mfw_pkg::COEF_W'(-int'(b_i) - 6 * int'(c_i));
    coef_d.p2_a2 = mfw_pkg::COEF_W'(6 * int'(b_i) + 30 * int'(c_i));
    coef_d.p2_a1 = mfw_pkg::COEF_W'(-12 * int'(b_i) - 48 * int'(c_i));
    coef_d.p2_a0 = mfw_pkg::COEF_W'(8 * int'(b_i) + 24 * int'(c_i));
  end

  // Hold coefficients in a register; they settle long before any word uses them
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

### src/mfw_kernel.sv
module mfw_kernel #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [COORD_WIDTH-1:0]        off_i,
  input  logic [mfw_pkg::REG_W-1:0]            inv_i,
  input  mfw_pkg::mfw_coef_t                   coef_i,
  output logic signed [mfw_pkg::KER_W-1:0]     kernel_o
);

  localparam int unsigned P_W   = COORD_WIDTH + mfw_pkg::REG_W;
  localparam int unsigned T26_W = (P_W + 1 > mfw_pkg::T26_TWO_BIT + 1) ?
                                  P_W + 1 : mfw_pkg::T26_TWO_BIT + 1;

  // Stage 1: magnitude times inverse width, exact t in Q.26
  logic [COORD_WIDTH-1:0] mag;
  logic [P_W-1:0]         prod1;
  logic [T26_W-1:0]       t26_d, t26_q;

  assign mag   = off_i[COORD_WIDTH-1] ? COORD_WIDTH'(~off_i + 1'b1) : off_i;
  assign prod1 = P_W'(mag) * P_W'(inv_i);
  assign t26_d = T26_W'({prod1, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t26_q <= t26_d;
    end
  end

  // Stage 2: piece select and t squared
  logic                        zero2_d, first2_d;
  logic [mfw_pkg::T_W-1:0]     t2s_t;
  logic [2*mfw_pkg::T_W-1:0]   sq;
  logic                        zero2_q, first2_q;
  logic [mfw_pkg::T_W-1:0]     t_s2_q;
  logic [mfw_pkg::T2_W-1:0]    tt_s2_q;

  assign zero2_d  = |t26_q[T26_W-1:mfw_pkg::T26_TWO_BIT];
  assign first2_d = ~t26_q[mfw_pkg::T26_ONE_BIT];
  assign t2s_t    = t26_q[mfw_pkg::T26_DROP +: mfw_pkg::T_W];
  assign sq       = (2 * mfw_pkg::T_W)'(t2s_t) * (2 * mfw_pkg::T_W)'(t2s_t);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero2_q  <= zero2_d;
      first2_q <= first2_d;
      t_s2_q   <= t2s_t;
      tt_s2_q  <= sq[mfw_pkg::FRAC_SHIFT +: mfw_pkg::T2_W];
    end
  end

  // Stage 3: t cubed
  logic [mfw_pkg::T2_W+mfw_pkg::T_W-1:0] cube;
  logic                        zero3_q, first3_q;
  logic [mfw_pkg::T_W-1:0]     t_s3_q;
  logic [mfw_pkg::T2_W-1:0]    tt_s3_q;
  logic [mfw_pkg::T3_W-1:0]    ttt_s3_q;

  assign cube = (mfw_pkg::T2_W + mfw_pkg::T_W)'(tt_s2_q) *
                (mfw_pkg::T2_W + mfw_pkg::T_W)'(t_s2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero3_q  <= zero2_q;
      first3_q <= first2_q;
      t_s3_q   <= t_s2_q;
      tt_s3_q  <= tt_s2_q;
      ttt_s3_q <= cube[mfw_pkg::FRAC_SHIFT +: mfw_pkg::T3_W];
    end
  end

  // Stage 4: pick the piece and form the three products
  logic signed [mfw_pkg::COEF_W-1:0] c3, c2, c1, c0;
  logic signed [mfw_pkg::PROD_W-1:0] p3_d, p2_d, p1_d;
  logic signed [mfw_pkg::PROD_W-1:0] p3_q, p2_q, p1_q;
  logic signed [mfw_pkg::COEF_W-1:0] c0_q;
  logic                              zero4_q;

  always_comb begin
    if (first3_q) begin
      c3 = coef_i.p1_a3;
      c2 = coef_i.p1_a2;
      c1 = '0;
      c0 = coef_i.p1_a0;
    end else begin
      c3 = coef_i.p2_a3;
      c2 = coef_i.p2_a2;
      c1 = coef_i.p2_a1;
      c0 = coef_i.p2_a0;
    end
    p3_d = mfw_pkg::PROD_W'(c3) * mfw_pkg::PROD_W'($signed({1'b0, ttt_s3_q}));
    p2_d = mfw_pkg::PROD_W'(c2) * mfw_pkg::PROD_W'($signed({1'b0, tt_s3_q}));
    p1_d = mfw_pkg::PROD_W'(c1) * mfw_pkg::PROD_W'($signed({1'b0, t_s3_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q    <= p3_d;
      p2_q    <= p2_d;
      p1_q    <= p1_d;
      c0_q    <= c0;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: polynomial sum, constant term scaled to Q.31
  logic signed [mfw_pkg::SUM_W-1:0] sum_d, sum_q;
  logic                             zero5_q;

  assign sum_d = p3_q + p2_q + p1_q +
                 (mfw_pkg::SUM_W'(c0_q) <<< mfw_pkg::FRAC_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: magnitude, round half up, drop the power-of-two part of 6*2^15
  logic                       neg6_d;
  logic [mfw_pkg::SUM_W-1:0]  smag, srnd;
  logic [mfw_pkg::M_W-1:0]    m_q;
  logic                       neg6_q, zero6_q;

  assign neg6_d = sum_q[mfw_pkg::SUM_W-1];
  assign smag   = neg6_d ? mfw_pkg::SUM_W'(-sum_q) : mfw_pkg::SUM_W'(sum_q);
  assign srnd   = smag + mfw_pkg::KER_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= srnd[mfw_pkg::FRAC_SHIFT +: mfw_pkg::M_W];
      neg6_q  <= neg6_d;
      zero6_q <= zero5_q;
    end
  end

  // Stage 7: divide by three through the reciprocal, restore sign
  logic [2*mfw_pkg::M_W-1:0]         qprod;
  logic [mfw_pkg::Q_W-1:0]           quo;
  logic signed [mfw_pkg::KER_W-1:0]  ker_d, ker_q;

  assign qprod = (2 * mfw_pkg::M_W)'(m_q) * (2 * mfw_pkg::M_W)'(mfw_pkg::RECIP3);
  assign quo   = qprod[mfw_pkg::RECIP_SHIFT +: mfw_pkg::Q_W];

  always_comb begin
    if (zero6_q) begin
      ker_d = '0;
    end else if (neg6_q) begin
      ker_d = -$signed({1'b0, quo});
    end else begin
      ker_d = $signed({1'b0, quo});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ker_q <= ker_d;
    end
  end

  assign kernel_o = ker_q;

endmodule

### src/mfw_combine.sv
module mfw_combine (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [mfw_pkg::KER_W-1:0]    kx_i,
  input  logic signed [mfw_pkg::KER_W-1:0]    ky_i,
  output logic [mfw_pkg::WEIGHT_W-1:0]        weight_o
);

  // Product stage: Kx * Ky in Q.32
  logic signed [mfw_pkg::WPROD_W-1:0] wprod_d, wprod_q;

  assign wprod_d = mfw_pkg::WPROD_W'(kx_i) * mfw_pkg::WPROD_W'(ky_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wprod_q <= wprod_d;
    end
  end

  // Output stage: round to Q.14 away from zero, then saturate
  logic                          neg;
  logic [mfw_pkg::WPROD_W-1:0]   wmag, wrnd;
  logic [mfw_pkg::WQ_W-1:0]      wq;
  logic                          ovf;
  logic [mfw_pkg::WEIGHT_W-1:0]  weight_d, weight_q;

  always_comb begin
    neg  = wprod_q[mfw_pkg::WPROD_W-1];
    wmag = neg ? mfw_pkg::WPROD_W'(-wprod_q) : mfw_pkg::WPROD_W'(wprod_q);
    wrnd = wmag + mfw_pkg::W_HALF;
    wq   = wrnd[mfw_pkg::W_SHIFT +: mfw_pkg::WQ_W];
    ovf  = |wq[mfw_pkg::WQ_W-1:mfw_pkg::WEIGHT_W-1];
    if (ovf) begin
      weight_d = neg ? mfw_pkg::WEIGHT_MIN : mfw_pkg::WEIGHT_MAX;
    end else if (neg) begin
      weight_d = mfw_pkg::WEIGHT_W'(~wq[mfw_pkg::WEIGHT_W-1:0] + 1'b1);
    end else begin
      weight_d = wq[mfw_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
    end
  end

  assign weight_o = weight_q;

endmodule
